### hw/rtl/bma_pkg.sv
// Shared constants, status codes and free-map layout functions for the buddy allocator.
package bma_pkg;

	// Free-map memory word: one bit per tree node, 32 nodes per row.
	localparam int WORD_W = 32;
	localparam int BIT_W = 5;

	localparam int DEF_MAX_ORDER = 10;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADSIZE = 2'd2;

	typedef logic [1:0] status_t;

	// Number of memory rows that hold the nodes of one order.
	function automatic int rows_of(input int o, input int mo);
		int c;
		c = 1 << (mo - o);
		return (c > WORD_W) ? (c >> BIT_W) : 1;
	endfunction

	// First memory row of one order; orders are stored from 0 upward.
	function automatic int row_base(input int o, input int mo);
		int s;
		s = 0;
		for (int q = 0; q < o; q++) begin
			s += rows_of(q, mo);
		end
		return s;
	endfunction

	// Total number of memory rows.
	function automatic int map_rows(input int mo);
		return row_base(mo, mo) + 1;
	endfunction

endpackage

### hw/rtl/bma_map_ram.sv
// Free-map memory: one write port and one read port with registered read data.
module bma_map_ram import bma_pkg::*; #(
	parameter int DEPTH = 63,
	parameter int AW = 6
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/bma_ctrl.sv
// Request sequencer: searches, splits and merges blocks through read-modify-write of the free map.
module bma_ctrl import bma_pkg::*; #(
	parameter int MAX_ORDER = DEF_MAX_ORDER,
	parameter int ROWS = map_rows(DEF_MAX_ORDER),
	parameter int ROW_W = $clog2(map_rows(DEF_MAX_ORDER))
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Request side.
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 req_type,
	input  logic [MAX_ORDER:0]   req_size,
	input  logic [MAX_ORDER-1:0] free_address,
	// Result side.
	output logic                 res_valid,
	input  logic                 res_ready,
	output status_t              res_status,
	output logic [MAX_ORDER-1:0] res_start,
	output logic [MAX_ORDER-1:0] res_end,
	// Free-map memory.
	output logic                 rd_en,
	output logic [ROW_W-1:0]     rd_addr,
	input  logic [WORD_W-1:0]    rd_data,
	output logic                 wr_en,
	output logic [ROW_W-1:0]     wr_addr,
	output logic [WORD_W-1:0]    wr_data
);

	localparam int AW = MAX_ORDER;
	localparam int ORD_W = $clog2(MAX_ORDER + 1);
	localparam int IDX_W = (MAX_ORDER > BIT_W) ? MAX_ORDER : BIT_W;
	localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(MAX_ORDER);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ARD   = 4'd2;
	localparam logic [3:0] S_ACHK  = 4'd3;
	localparam logic [3:0] S_SRD   = 4'd4;
	localparam logic [3:0] S_SWR   = 4'd5;
	localparam logic [3:0] S_FRD   = 4'd6;
	localparam logic [3:0] S_FCHK  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	// Row layout tables, one entry per order.
	logic [ROW_W-1:0] base_tab [MAX_ORDER+1];
	logic [ROW_W-1:0] last_tab [MAX_ORDER+1];

	for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_tab
		assign base_tab[g] = ROW_W'(row_base(g, MAX_ORDER));
		assign last_tab[g] = ROW_W'(row_base(g, MAX_ORDER) + rows_of(g, MAX_ORDER) - 1);
	end

	logic [3:0]       state_q;
	logic [ROW_W-1:0] row_q;
	logic [ORD_W-1:0] ord_q;
	logic [ORD_W-1:0] tgt_q;
	logic [AW-1:0]    addr_q;
	status_t          status_q;
	logic [AW-1:0]    start_q;
	logic [AW-1:0]    end_q;

	// Low mask of an order: block size minus one.
	function automatic logic [AW-1:0] low_mask(input logic [ORD_W-1:0] o);
		logic [AW:0] one;
		one = (AW+1)'(1) << o;
		return AW'(one - 1'b1);
	endfunction

	// Rounded order of a size: smallest k with 2^k not below the size.
	function automatic logic [ORD_W-1:0] order_of(input logic [AW:0] s);
		logic [AW:0] d;
		logic [ORD_W-1:0] k;
		d = s - 1'b1;
		k = '0;
		for (int b = 0; b < AW; b++) begin
			if (d[b]) begin
				k = ORD_W'(b + 1);
			end
		end
		return k;
	endfunction

	// Memory row that holds a node index of an order.
	function automatic logic [ROW_W-1:0] row_of(input logic [ORD_W-1:0] o,
			input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] hi;
		hi = i >> BIT_W;
		return base_tab[o] + ROW_W'(hi);
	endfunction

	// Request decode.
	logic [ORD_W-1:0] req_ord;
	logic             req_bad;
	logic [AW-1:0]    req_addr;

	always_comb begin
		req_ord = order_of(req_size);
		req_bad = (req_size == '0) || (req_size > (AW+1)'(1 << MAX_ORDER));
		req_addr = free_address & ~low_mask(req_ord);
	end

	// Lowest free node in the row just read.
	logic [BIT_W-1:0] low_bit;

	always_comb begin
		low_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (rd_data[b]) begin
				low_bit = BIT_W'(b);
			end
		end
	end

	// Address of the block found by the search.
	logic [ROW_W-1:0]       rel_row;
	logic [ROW_W+BIT_W-1:0] found_cat;
	logic [IDX_W-1:0]       found_idx;
	logic [AW-1:0]          found_addr;

	always_comb begin
		rel_row = row_q - base_tab[ord_q];
		found_cat = {rel_row, low_bit};
		found_idx = IDX_W'(found_cat);
		found_addr = AW'(found_idx << ord_q);
	end

	// Node indexes for the split and merge steps.
	logic [ORD_W-1:0] ord_dn;
	logic [ORD_W-1:0] ord_up;
	logic [IDX_W-1:0] found_half;
	logic [IDX_W-1:0] split_half;
	logic [IDX_W-1:0] split_idx;
	logic [IDX_W-1:0] self_idx;
	logic [BIT_W-1:0] buddy_bit;
	logic [AW-1:0]    merged_addr;
	logic [IDX_W-1:0] merged_idx;

	always_comb begin
		ord_dn = ord_q - 1'b1;
		ord_up = ord_q + 1'b1;
		found_half = (IDX_W'(found_addr) >> ord_dn) | IDX_W'(1);
		split_half = (IDX_W'(addr_q) >> ord_dn) | IDX_W'(1);
		split_idx = (IDX_W'(addr_q) >> ord_q) | IDX_W'(1);
		self_idx = IDX_W'(addr_q) >> ord_q;
		buddy_bit = self_idx[BIT_W-1:0] ^ BIT_W'(1);
		merged_addr = addr_q & ~(AW'(1) << ord_q);
		merged_idx = IDX_W'(merged_addr) >> ord_up;
	end

	// Memory port drive.
	always_comb begin
		rd_en = (state_q == S_ARD) || (state_q == S_SRD) || (state_q == S_FRD);
		rd_addr = row_q;
		wr_en = 1'b0;
		wr_addr = row_q;
		wr_data = rd_data;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_data = (row_q == ROW_LAST) ? WORD_W'(1) : '0;
			end
			S_ACHK: begin
				wr_en = (rd_data != '0);
				wr_data = rd_data & ~(WORD_W'(1) << low_bit);
			end
			S_SWR: begin
				wr_en = 1'b1;
				wr_data = rd_data | (WORD_W'(1) << split_idx[BIT_W-1:0]);
			end
			S_FCHK: begin
				wr_en = 1'b1;
				if (ord_q != ORD_MAX && rd_data[buddy_bit]) begin
					wr_data = rd_data & ~(WORD_W'(1) << buddy_bit);
				end else begin
					wr_data = rd_data | (WORD_W'(1) << self_idx[BIT_W-1:0]);
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			row_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					row_q <= row_q + 1'b1;
					if (row_q == ROW_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						ord_q <= req_ord;
						tgt_q <= req_ord;
						addr_q <= req_addr;
						if (req_bad) begin
							status_q <= ST_BADSIZE;
							start_q <= '0;
							end_q <= '0;
							state_q <= S_DONE;
						end else if (!req_type) begin
							row_q <= base_tab[req_ord];
							state_q <= S_ARD;
						end else begin
							row_q <= row_of(req_ord, IDX_W'(req_addr) >> req_ord);
							state_q <= S_FRD;
						end
					end
				end
				S_ARD: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					if (rd_data != '0) begin
						addr_q <= found_addr;
						if (ord_q == tgt_q) begin
							status_q <= ST_OK;
							start_q <= found_addr;
							end_q <= found_addr | low_mask(tgt_q);
							state_q <= S_DONE;
						end else begin
							ord_q <= ord_dn;
							row_q <= row_of(ord_dn, found_half);
							state_q <= S_SRD;
						end
					end else if (row_q == last_tab[ord_q] && ord_q == ORD_MAX) begin
						status_q <= ST_NOSPACE;
						start_q <= '0;
						end_q <= '0;
						state_q <= S_DONE;
					end else begin
						// Rows are laid out by order, so the next row is the next candidate.
						if (row_q == last_tab[ord_q]) begin
							ord_q <= ord_up;
						end
						row_q <= row_q + 1'b1;
						state_q <= S_ARD;
					end
				end
				S_SRD: begin
					state_q <= S_SWR;
				end
				S_SWR: begin
					if (ord_q == tgt_q) begin
						status_q <= ST_OK;
						start_q <= addr_q;
						end_q <= addr_q | low_mask(tgt_q);
						state_q <= S_DONE;
					end else begin
						ord_q <= ord_dn;
						row_q <= row_of(ord_dn, split_half);
						state_q <= S_SRD;
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (ord_q != ORD_MAX && rd_data[buddy_bit]) begin
						ord_q <= ord_up;
						addr_q <= merged_addr;
						row_q <= row_of(ord_up, merged_idx);
						state_q <= S_FRD;
					end else begin
						status_q <= ST_OK;
						start_q <= addr_q;
						end_q <= addr_q | low_mask(ord_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_status = status_q;
	assign res_start = start_q;
	assign res_end = end_q;

endmodule

### hw/rtl/buddy_memory_allocator.sv
// Top level of the buddy allocator: sequencer, free-map memory and result register.
//
// Binary buddy allocator over a region of 2^MAX_ORDER bytes.
// A request word (req_type, req_size, free_address) is taken on req_valid and
// req_ready; one result word (status, block_start, block_end) leaves on
// rsp_valid and rsp_ready for every request.
// The free map holds one bit per tree node in a memory of 32-bit rows
// (68 rows at the default order), read and written back one row at a time.
// One request is worked on at a time; the next is taken the cycle after the
// result moves to the output register. Memory work is read-modify-write of
// one row at a time: a bad size needs none, an allocation scans rows of
// orders k to MAX_ORDER (up to 68 rows) and then updates one row per split
// level, and a free reads and writes one row per merge level tried.
// After reset the block sweeps the memory, one row a cycle, and takes no
// request until the sweep ends; only the whole region is then free.
// A finished result waits in the output register while the next request is
// taken; a stalled receiver holds the sequencer only once a second result
// is ready.
module buddy_memory_allocator import bma_pkg::*; #(
	parameter int MAX_ORDER = DEF_MAX_ORDER
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 req_type,
	input  logic [MAX_ORDER:0]   req_size,
	input  logic [MAX_ORDER-1:0] free_address,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [1:0]           status,
	output logic [MAX_ORDER-1:0] block_start,
	output logic [MAX_ORDER-1:0] block_end
);

	localparam int ROWS = map_rows(MAX_ORDER);
	localparam int ROW_W = $clog2(ROWS);

	logic              res_valid;
	logic              res_ready;
	status_t           res_status;
	logic [MAX_ORDER-1:0] res_start;
	logic [MAX_ORDER-1:0] res_end;
	logic              rd_en;
	logic [ROW_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [ROW_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;

	bma_ctrl #(
		.MAX_ORDER (MAX_ORDER),
		.ROWS      (ROWS),
		.ROW_W     (ROW_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.req_size     (req_size),
		.free_address (free_address),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_status   (res_status),
		.res_start    (res_start),
		.res_end      (res_end),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

	bma_map_ram #(
		.DEPTH (ROWS),
		.AW    (ROW_W)
	) u_map (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Output register: loads when empty or when its word is being taken.
	logic                 out_valid_q;
	status_t              status_q;
	logic [MAX_ORDER-1:0] start_q;
	logic [MAX_ORDER-1:0] end_q;

	assign res_ready = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			status_q <= res_status;
			start_q <= res_start;
			end_q <= res_end;
		end
	end

	assign rsp_valid = out_valid_q;
	assign status = status_q;
	assign block_start = start_q;
	assign block_end = end_q;

endmodule

### sim/buddy_memory_allocator_tb.sv
// Testbench for the buddy allocator: directed table, random traffic and a free-map predictor.
`timescale 1ns / 1ps

module buddy_memory_allocator_tb;
	import bma_pkg::*;

	localparam int MO = DEF_MAX_ORDER;
	localparam int REGION = 1 << MO;
	localparam int NODES = (2 << MO) - 1;
	localparam int N_RANDOM = 1330;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	// One request word and its result word.
	typedef struct {
		logic        op;
		logic [10:0] size;
		logic [9:0]  addr;
	} req_word_t;

	typedef struct {
		status_t    st;
		logic [9:0] bstart;
		logic [9:0] bend;
	} rsp_word_t;

	// One row of the directed table; has_fixed marks a typed-in result.
	typedef struct {
		logic        op;
		logic [10:0] size;
		logic [9:0]  addr;
		bit          has_fixed;
		status_t     st;
		logic [9:0]  bstart;
		logic [9:0]  bend;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	logic req_type;
	logic [MO:0] req_size;
	logic [MO-1:0] free_address;
	logic rsp_valid;
	logic rsp_ready;
	status_t status;
	logic [MO-1:0] block_start;
	logic [MO-1:0] block_end;

	bit free_map [NODES];
	rsp_word_t pending_rsp [$];
	int errors;
	int n_rsp;
	int n_alloc_ok;
	int n_nospace;
	int n_badsize;
	int n_free;
	bit stall_long;

	buddy_memory_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.req_size(req_size),
		.free_address(free_address),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.block_start(block_start),
		.block_end(block_end)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Smallest order whose block holds the size.
	function automatic int order_for(input int sz);
		int k;
		k = 0;
		while (k < MO && (1 << k) < sz) k++;
		return k;
	endfunction

	function automatic int node_at(input int o, input int a);
		int n;
		n = ((1 << (MO - o)) - 1) + (a >> o);
		return (n < NODES) ? n : 0;
	endfunction

	// Apply one request to the free map and return its result.
	function automatic rsp_word_t buddy_apply(input req_word_t rq);
		rsp_word_t r;
		int k;
		int a;
		int j;
		int bn;
		bit found;
		r.st = ST_OK;
		r.bstart = '0;
		r.bend = '0;
		found = 0;
		a = 0;
		if (rq.size == 0 || rq.size > REGION) begin
			r.st = ST_BADSIZE;
		end else if (rq.op == OP_ALLOC) begin
			k = order_for(rq.size);
			for (int o = k; o <= MO && !found; o++) begin
				for (int i = 0; i < (1 << (MO - o)); i++) begin
					if (free_map[(1 << (MO - o)) - 1 + i]) begin
						found = 1;
						a = i << o;
						free_map[(1 << (MO - o)) - 1 + i] = 0;
						break;
					end
				end
				if (found) begin
					j = o;
					while (j > k) begin
						j--;
						free_map[node_at(j, a + (1 << j))] = 1;
					end
				end
			end
			if (found) begin
				r.bstart = 10'(a);
				r.bend = 10'(a + (1 << k) - 1);
			end else begin
				r.st = ST_NOSPACE;
			end
		end else begin
			k = order_for(rq.size);
			a = rq.addr & (REGION - 1) & ~((1 << k) - 1);
			while (k < MO) begin
				bn = node_at(k, a ^ (1 << k));
				if (!free_map[bn]) break;
				free_map[bn] = 0;
				k++;
				a &= ~((1 << k) - 1);
			end
			free_map[node_at(k, a)] = 1;
			r.bstart = 10'(a);
			r.bend = 10'(a + (1 << k) - 1);
		end
		return r;
	endfunction

	// Gap length: mostly none or short, sometimes long.
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drive one word until accepted; expect the caller's fixed result, else the predictor's.
	// Valid stays high after acceptance so that words can follow back to back.
	task automatic send_word(input req_word_t rq, input bit has_fixed, input rsp_word_t fixed);
		rsp_word_t pred;
		int g;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= rq.op;
		req_size <= rq.size;
		free_address <= rq.addr;
		do @(posedge clk); while (!req_ready);
		pred = buddy_apply(rq);
		if (has_fixed && (pred.st != fixed.st || pred.bstart != fixed.bstart
			|| pred.bend != fixed.bend)) begin
			$display("%0t predictor disagrees with table: expected %0d/%0d/%0d got %0d/%0d/%0d",
				$time, fixed.st, fixed.bstart, fixed.bend, pred.st, pred.bstart, pred.bend);
			errors++;
		end
		pending_rsp.push_back(has_fixed ? fixed : pred);
	endtask

	// Random request, mostly well-formed and aimed at live blocks.
	function automatic req_word_t rand_word(inout int live_start [$], inout int live_size [$]);
		req_word_t rq;
		int p;
		int idx;
		p = $urandom_range(99);
		rq.addr = 10'($urandom);
		if (p < 48) begin
			rq.op = OP_ALLOC;
			rq.size = ($urandom_range(3) == 0) ? 11'($urandom_range(1, 1024))
				: 11'($urandom_range(1, 1 << $urandom_range(0, 7)));
		end else if (p < 90 && live_start.size() > 0) begin
			idx = $urandom_range(live_start.size() - 1);
			rq.op = OP_FREE;
			rq.addr = 10'(live_start[idx]);
			rq.size = 11'(live_size[idx]);
			live_start.delete(idx);
			live_size.delete(idx);
		end else begin
			rq.op = 1'($urandom);
			rq.size = ($urandom_range(1) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1024));
		end
		return rq;
	endfunction

	// Receiver: random stalls, compare against the oldest expectation.
	initial begin
		rsp_word_t exp_rsp;
		int g;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			g = stall_long ? 0 : gap_len();
			rsp_ready <= (g == 0);
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				n_rsp++;
				if (pending_rsp.size() == 0) begin
					$display("%0t unexpected result %0d/%0d/%0d", $time, status,
						block_start, block_end);
					errors++;
				end else begin
					exp_rsp = pending_rsp.pop_front();
					if (status !== exp_rsp.st || block_start !== exp_rsp.bstart
						|| block_end !== exp_rsp.bend) begin
						$display("%0t mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d", $time,
							exp_rsp.st, exp_rsp.bstart, exp_rsp.bend, status, block_start,
							block_end);
						errors++;
					end
					if (exp_rsp.st == ST_NOSPACE) n_nospace++;
					if (exp_rsp.st == ST_BADSIZE) n_badsize++;
				end
			end
			if (g > 1) begin
				repeat (g - 1) @(posedge clk);
			end
		end
	end

	// Stimulus.
	initial begin
		dir_row_t tbl [$];
		req_word_t rq;
		rsp_word_t fx;
		rsp_word_t none;
		int live_start [$];
		int live_size [$];
		int wait_cnt;
		errors = 0;
		n_rsp = 0;
		n_nospace = 0;
		n_badsize = 0;
		n_alloc_ok = 0;
		n_free = 0;
		stall_long = 0;
		none = '{st: ST_OK, bstart: '0, bend: '0};
		for (int i = 0; i < NODES; i++) free_map[i] = (i == 0);
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = OP_ALLOC;
		req_size = '0;
		free_address = '0;

		// Bad sizes, whole region, no space, smallest blocks, merges and odd frees.
		tbl = '{
			'{OP_ALLOC, 11'd0, 10'd0, 1'b1, ST_BADSIZE, 10'd0, 10'd0},
			'{OP_FREE, 11'd0, 10'd1023, 1'b1, ST_BADSIZE, 10'd0, 10'd0},
			'{OP_ALLOC, 11'd1025, 10'd0, 1'b1, ST_BADSIZE, 10'd0, 10'd0},
			'{OP_FREE, 11'd2047, 10'd5, 1'b1, ST_BADSIZE, 10'd0, 10'd0},
			'{OP_ALLOC, 11'd1024, 10'd0, 1'b1, ST_OK, 10'd0, 10'd1023},
			'{OP_ALLOC, 11'd1, 10'd0, 1'b1, ST_NOSPACE, 10'd0, 10'd0},
			'{OP_FREE, 11'd1024, 10'd777, 1'b1, ST_OK, 10'd0, 10'd1023},
			'{OP_ALLOC, 11'd1, 10'd1023, 1'b1, ST_OK, 10'd0, 10'd0},
			'{OP_ALLOC, 11'd1, 10'd0, 1'b1, ST_OK, 10'd1, 10'd1},
			'{OP_ALLOC, 11'd3, 10'd0, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_ALLOC, 11'd513, 10'd0, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_ALLOC, 11'd512, 10'd0, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_FREE, 11'd1, 10'd1, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_FREE, 11'd1, 10'd0, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_FREE, 11'd4, 10'd6, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_FREE, 11'd4, 10'd6, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_FREE, 11'd512, 10'd1023, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_ALLOC, 11'd1024, 10'd0, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_FREE, 11'd1024, 10'd0, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_ALLOC, 11'd1023, 10'd682, 1'b0, ST_OK, 10'd0, 10'd0},
			'{OP_FREE, 11'd700, 10'd341, 1'b0, ST_OK, 10'd0, 10'd0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (tbl[i]) begin
			rq = '{op: tbl[i].op, size: tbl[i].size, addr: tbl[i].addr};
			fx = '{st: tbl[i].st, bstart: tbl[i].bstart, bend: tbl[i].bend};
			send_word(rq, tbl[i].has_fixed, tbl[i].has_fixed ? fx : none);
		end

		// Random traffic; the free map after the directed part is whatever the predictor holds.
		for (int n = 0; n < N_RANDOM; n++) begin
			rq = rand_word(live_start, live_size);
			if (rq.op == OP_ALLOC && rq.size != 0 && rq.size <= REGION) begin
				send_word(rq, 0, none);
				if (pending_rsp[$].st == ST_OK) begin
					n_alloc_ok++;
					live_start.push_back(pending_rsp[$].bstart);
					live_size.push_back(rq.size);
				end
			end else begin
				if (rq.op == OP_FREE) n_free++;
				send_word(rq, 0, none);
			end
			// Drain completely now and then, and stretch a phase with no stalls.
			if (n % 300 == 150) begin
				req_valid <= 1'b0;
				wait_cnt = 0;
				while (pending_rsp.size() != 0 && wait_cnt < 20000) begin
					@(posedge clk);
					wait_cnt++;
				end
				stall_long = !stall_long;
			end
		end

		req_valid <= 1'b0;
		wait_cnt = 0;
		while (pending_rsp.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$display("%0t %0d results never arrived", $time, pending_rsp.size());
			errors++;
		end
		$display("Ran %0d requests, %0d results: %0d good allocations, %0d frees,",
			tbl.size() + N_RANDOM, n_rsp, n_alloc_ok, n_free);
		$display("%0d out-of-space and %0d bad-size results, %0d errors.", n_nospace,
			n_badsize, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog: ends the run with TB_ERROR if it hangs.
	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
